// ===== rtl/core/dcd_pkg.sv =====
// Package for the directed cycle detector: widths, visit mark codes.
// No dependencies.
package dcd_pkg;
  localparam int unsigned MarkW = 2;
  localparam logic [MarkW-1:0] MarkNone = 2'd0;
  localparam logic [MarkW-1:0] MarkPath = 2'd1;
  localparam logic [MarkW-1:0] MarkDone = 2'd2;
endpackage

// ===== rtl/core/dcd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module dcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/directed_cycle_detect.sv =====
// Directed cycle detector top level: pair loader, DFS sequencer, memories.
// Depends on dcd_pkg and dcd_ram.
//
//  channel  dir  fields
//  s_axis   in   tdata[0]=red, tlast=last_pair
//  m_axis   out  tdata[0]=acyclic
//  cfg      in   vertex_count (7 bits)
//
// A pair is accepted, then its row gets a read-modify-write (the row
// read issued at accept returns in the write cycle, so no forwarding is needed).
// After the last pair the visit marks are cleared. A root check reads, then tests
// its mark; a neighbor probe does stack read, row/mark read, then decides.
// The result holds until taken. Reset clears control.
// No request is taken while a search runs or a result waits.
module directed_cycle_detect #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] red
  input  logic       s_axis_tlast,   // last_pair
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] acyclic
);
  import dcd_pkg::*;
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MaxV = CW'(MAX_VERTICES);

  localparam logic [3:0] StLoad = 4'd0, StLdWr = 4'd1, StClr = 4'd2,
    StRoot = 4'd3, StRootRd = 4'd4, StTop = 4'd5, StTopRd = 4'd6,
    StEdge = 4'd7, StMark = 4'd8, StOut = 4'd9;

  logic [3:0] st_q, st_d;
  logic [6:0] cnt_q;
  logic [CW-1:0] n;
  assign n = (cnt_q > 7'(MaxV)) ? MaxV : CW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 7'd1;
    else if (cfg_we_i) cnt_q <= cfg_wdata_i;
  end

  // memories
  logic row_we; logic [AW-1:0] row_wa, row_ra;
  logic [MAX_VERTICES-1:0] row_wd, row_rd;
  logic mk_we; logic [AW-1:0] mk_wa, mk_ra; logic [MarkW-1:0] mk_wd, mk_rd;
  logic sk_we; logic [AW-1:0] sk_wa, sk_ra; logic [AW+CW-1:0] sk_wd, sk_rd;

  dcd_ram #(.Width(MAX_VERTICES), .Depth(MAX_VERTICES)) u_rows (
    .clk_i, .we_i(row_we), .waddr_i(row_wa), .wdata_i(row_wd),
    .raddr_i(row_ra), .rdata_o(row_rd));
  dcd_ram #(.Width(MarkW), .Depth(MAX_VERTICES)) u_marks (
    .clk_i, .we_i(mk_we), .waddr_i(mk_wa), .wdata_i(mk_wd),
    .raddr_i(mk_ra), .rdata_o(mk_rd));
  dcd_ram #(.Width(AW+CW), .Depth(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(sk_we), .waddr_i(sk_wa), .wdata_i(sk_wd),
    .raddr_i(sk_ra), .rdata_o(sk_rd));

  logic [AW-1:0] lrow_q, lrow_d;
  logic [CW-1:0] lcol_q, lcol_d;
  logic [CW-1:0] root_q, root_d, dep_q, dep_d, i_q, i_d;
  logic [AW-1:0] v_q, v_d, nb_q, nb_d;
  logic red_q, red_d, last_q, last_d, cyc_q, cyc_d;
  logic [AW-1:0] wr_row_q, wr_row_d; logic [CW-1:0] wr_col_q, wr_col_d;
  logic wr_en_q, wr_en_d;
  logic edge_hit;
  logic [AW-1:0] top;
  assign top = AW'(dep_q - CW'(1));

  // edge v->nb: v<nb uses row v bit nb; else row nb bit v inverted
  assign edge_hit = (v_q < nb_q) ? row_rd[nb_q] : !row_rd[v_q];

  assign s_axis_tready = (st_q == StLoad) && !m_axis_tvalid;
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata  = {7'd0, !cyc_q};

  always_comb begin
    st_d = st_q; lrow_d = lrow_q; lcol_d = lcol_q; root_d = root_q;
    dep_d = dep_q; i_d = i_q; v_d = v_q; nb_d = nb_q;
    red_d = red_q; last_d = last_q; cyc_d = cyc_q;
    wr_row_d = wr_row_q; wr_col_d = wr_col_q; wr_en_d = wr_en_q;
    row_we = 1'b0; row_wa = wr_row_q; row_ra = lrow_q;
    row_wd = row_rd;
    row_wd[wr_col_q[AW-1:0]] = red_q;
    mk_we = 1'b0; mk_wa = '0; mk_wd = MarkNone; mk_ra = '0;
    sk_we = 1'b0; sk_wa = top; sk_wd = '0; sk_ra = top;
    unique case (st_q)
      StLoad: begin
        row_ra = lrow_q;
        if (s_axis_tvalid && s_axis_tready) begin
          red_d = s_axis_tdata[0]; last_d = s_axis_tlast;
          wr_row_d = lrow_q; wr_col_d = lcol_q;
          wr_en_d = (CW'(lrow_q) + CW'(1) < n) && (lcol_q < n) &&
                    (lcol_q > CW'(lrow_q));
          if (wr_en_d) begin
            if (lcol_q + CW'(1) >= n) begin
              lrow_d = lrow_q + AW'(1); lcol_d = CW'(lrow_q) + CW'(2);
            end else lcol_d = lcol_q + CW'(1);
          end
          st_d = StLdWr;
        end
      end
      StLdWr: begin
        row_we = wr_en_q;
        i_d = '0;
        st_d = last_q ? StClr : StLoad;
      end
      StClr: begin
        mk_we = 1'b1; mk_wa = i_q[AW-1:0]; mk_wd = MarkNone;
        i_d = i_q + CW'(1);
        if (i_q + CW'(1) >= n) begin
          st_d = StRoot; root_d = '0; dep_d = '0; cyc_d = 1'b0;
        end
      end
      StRoot: begin
        if (root_q >= n) st_d = StOut;
        else begin mk_ra = root_q[AW-1:0]; st_d = StRootRd; end
      end
      StRootRd: begin
        if (mk_rd != MarkNone) begin
          root_d = root_q + CW'(1); st_d = StRoot;
        end else begin
          sk_we = 1'b1; sk_wa = '0; sk_wd = {CW'(0), root_q[AW-1:0]};
          mk_we = 1'b1; mk_wa = root_q[AW-1:0]; mk_wd = MarkPath;
          dep_d = CW'(1); st_d = StTop;
        end
      end
      StTop: begin
        if (dep_q == '0) begin
          root_d = root_q + CW'(1); st_d = StRoot;
        end else begin sk_ra = top; st_d = StTopRd; end
      end
      StTopRd: begin
        v_d = sk_rd[AW-1:0];
        if (sk_rd[AW+CW-1:AW] >= n) begin
          mk_we = 1'b1; mk_wa = sk_rd[AW-1:0]; mk_wd = MarkDone;
          dep_d = dep_q - CW'(1); st_d = StTop;
        end else begin
          sk_we = 1'b1; sk_wa = top;
          sk_wd = {sk_rd[AW+CW-1:AW] + CW'(1), sk_rd[AW-1:0]};
          nb_d = sk_rd[AW+AW-1:AW];
          row_ra = (sk_rd[AW-1:0] < sk_rd[AW+AW-1:AW]) ? sk_rd[AW-1:0]
                                                       : sk_rd[AW+AW-1:AW];
          mk_ra = sk_rd[AW+AW-1:AW];
          st_d = StEdge;
        end
      end
      StEdge: begin
        if (nb_q == v_q || !edge_hit || mk_rd == MarkDone) st_d = StTop;
        else if (mk_rd == MarkPath) begin cyc_d = 1'b1; st_d = StOut; end
        else st_d = StMark;
      end
      StMark: begin
        // push nb; depth never exceeds n since each vertex pushed once
        sk_we = 1'b1; sk_wa = AW'(dep_q); sk_wd = {CW'(0), nb_q};
        mk_we = 1'b1; mk_wa = nb_q; mk_wd = MarkPath;
        dep_d = dep_q + CW'(1); st_d = StTop;
      end
      StOut: begin
        if (m_axis_tready) begin
          st_d = StLoad; lrow_d = '0; lcol_d = CW'(1); dep_d = '0;
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; lrow_q <= '0; lcol_q <= CW'(1); root_q <= '0;
      dep_q <= '0; cyc_q <= 1'b0;
    end else begin
      st_q <= st_d; lrow_q <= lrow_d; lcol_q <= lcol_d; root_q <= root_d;
      dep_q <= dep_d; cyc_q <= cyc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; v_q <= v_d; nb_q <= nb_d; red_q <= red_d;
    last_q <= last_d; wr_row_q <= wr_row_d; wr_col_q <= wr_col_d;
    wr_en_q <= wr_en_d;
  end
endmodule

// ===== rtl/core/dcd_checker.sv =====
// Port-level checks for the directed cycle detector, bound to the top.
// Depends on directed_cycle_detect.
module dcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0) else $error("pad bits");
endmodule

bind directed_cycle_detect dcd_checker u_dcd_checker (.*);
